>>> design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level functions for the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned KeyWordsMax = 60;
  localparam int unsigned RoundKeys   = 15;
  localparam int unsigned KeyAddrW    = 6;
  localparam int unsigned RoundW      = 4;
  localparam int unsigned PaddrW      = 6;

  localparam logic [1:0] KeyMode128  = 2'd0;
  localparam logic [1:0] KeyMode192  = 2'd1;
  localparam logic [1:0] KeyMode256  = 2'd2;
  localparam logic [1:0] KeyModeRsvd = 2'd3;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegMode = 3'd4;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic                key_wr;    // write one schedule word
    logic [KeyAddrW-1:0] key_idx;   // word index being expanded
    logic                key_seed;  // word comes straight from the key registers
    logic                load;      // load block
    logic                add0;      // add first round key
    logic                round;     // run one round
    logic                last;      // current round is the final one
    logic [RoundW-1:0]   rk_round;  // round key selected for this cycle
    logic                rk_fetch;  // read round key
  } ctl_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] t;
    acc = 8'h00;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ t;
      t = xtime(t);
    end
    gmul = acc;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    rotl = (x << n) | (x >> (8 - n));
  endfunction

  // 256-entry byte tables, built at elaboration
  function automatic logic [2047:0] build_sbox(input logic dec);
    logic [2047:0] tab;
    logic [7:0]    x;
    logic [7:0]    v;
    tab = '0;
    for (int n = 0; n < 256; n++) begin
      x = 8'(n);
      if (dec) begin
        v = ginv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
      end else begin
        v = ginv(x);
        v = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
      end
      tab[8*n +: 8] = v;
    end
    build_sbox = tab;
  endfunction

  localparam logic [2047:0] SboxFwd = build_sbox(1'b0);
  localparam logic [2047:0] SboxInv = build_sbox(1'b1);

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SboxFwd[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] sbox_dec(input logic [7:0] x);
    sbox_dec = SboxInv[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

>>> design/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// aes_block_cipher
// FIPS-197 AES-128/192/256 encrypt/decrypt, one round per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | input     | in_valid_i/stall_o | action, block_high, block_low
//  out     | output    | out_valid_o/stall_i| result_high, result_low
//  cfg     | input     | APB psel/penable   | key regs 0..3 (64b), size mode
//
//  Steps per word: load, key add, Nr rounds, unload.
//  After any register write the first word also waits for the expansion
//  of the full schedule into the round-key store plus one key read.
//  Reset clears control and the schedule-ready flag; the store is not cleared.
//  A held result stalls intake until the sink takes it.
// ----------------------------------------------------------------------------
module aes_block_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  aes_pkg::in_word_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output aes_pkg::out_word_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [aes_pkg::PaddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  logic [63:0] key_q [4];
  logic [1:0]  mode_q;
  logic        wr, dirty;
  logic [2:0]  ridx;
  aes_pkg::ctl_cmd_t cmd;

  assign pready = 1'b1;
  assign wr   = psel && penable && pwrite;
  assign ridx = paddr[5:3];
  assign dirty = wr && (ridx <= aes_pkg::RegMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      mode_q <= '0;
    end else if (wr) begin
      case (ridx)
        aes_pkg::RegKey0: key_q[0] <= pwdata;
        aes_pkg::RegKey1: key_q[1] <= pwdata;
        aes_pkg::RegKey2: key_q[2] <= pwdata;
        aes_pkg::RegKey3: key_q[3] <= pwdata;
        aes_pkg::RegMode: mode_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      aes_pkg::RegKey0: prdata = key_q[0];
      aes_pkg::RegKey1: prdata = key_q[1];
      aes_pkg::RegKey2: prdata = key_q[2];
      aes_pkg::RegKey3: prdata = key_q[3];
      aes_pkg::RegMode: prdata = {62'd0, mode_q};
      default:          prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .key_dirty_i (dirty),
    .mode_i      (mode_q),
    .in_valid_i,
    .in_stall_o,
    .in_action_i (in_data_i.action),
    .out_valid_o,
    .out_stall_i,
    .cmd_o       (cmd)
  );

  aes_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .key_i  ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .mode_i (mode_q),
    .in_i   (in_data_i),
    .out_o  (out_data_o)
  );

endmodule

>>> design/aes_datapath.sv
// ----------------------------------------------------------------------------
// aes_datapath
// Key schedule store, round-key expansion and one-round-per-cycle state.
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aes_pkg::ctl_cmd_t    cmd_i,
  input  logic [255:0]         key_i,
  input  logic [1:0]           mode_i,
  input  aes_pkg::in_word_t    in_i,
  output aes_pkg::out_word_t   out_o
);

  logic [127:0] rk_mem [aes_pkg::RoundKeys];  // one 128-bit round key per entry
  logic [31:0] prev_q, prev_d;           // word i-1
  logic [31:0] hist_q [8];               // last eight words, [0] newest
  logic [7:0]  rc_q, rc_d;
  logic [2:0]  pos_q, pos_d;             // i mod nk
  logic [2:0]  nk_m1;
  logic [127:0] rk_q;
  logic [127:0] st_q, st_d;
  logic        dec_q;
  logic [31:0] new_w, t;
  logic [3:0]  nk;

  assign nk    = (mode_i == aes_pkg::KeyMode128) ? 4'd4 :
                 (mode_i == aes_pkg::KeyMode192) ? 4'd6 : 4'd8;
  assign nk_m1 = 3'(nk - 4'd1);

  // expansion word
  always_comb begin
    t = prev_q;
    prev_d = prev_q;
    rc_d = rc_q;
    pos_d = pos_q;
    new_w = '0;
    if (cmd_i.key_seed) begin
      new_w = key_i[255 - 32*cmd_i.key_idx[2:0] -: 32];
      pos_d = (cmd_i.key_idx[2:0] == nk_m1) ? 3'd0 : 3'(cmd_i.key_idx[2:0] + 3'd1);
      rc_d = 8'h01;
    end else begin
      if (pos_q == 3'd0) begin
        t = aes_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'h0};
        rc_d = aes_pkg::xtime(rc_q);
      end else if (nk == 4'd8 && pos_q == 3'd4) begin
        t = aes_pkg::sub_word(prev_q);
      end
      new_w = hist_q[nk_m1] ^ t;
      pos_d = (pos_q == nk_m1) ? 3'd0 : 3'(pos_q + 3'd1);
    end
    if (cmd_i.key_wr) prev_d = new_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= 8'h01;
      pos_q <= 3'd0;
    end else if (cmd_i.key_wr) begin
      rc_q <= rc_d;
      pos_q <= pos_d;
    end
  end

  // word 4r+c lands in lane c of round key r
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      rk_mem[cmd_i.key_idx[5:2]][127 - 32*cmd_i.key_idx[1:0] -: 32] <= new_w;
      prev_q <= prev_d;
      hist_q[0] <= new_w;
      for (int i = 1; i < 8; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  // round key fetch: one entry, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_fetch) rk_q <= rk_mem[cmd_i.rk_round];
  end

  // round
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3;
    for (int n = 0; n < 16; n++) b[n] = aes_pkg::sbox(s[127-8*n -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) o[r + 4*c] = b[r + 4*((c + r) % 4)];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
        o[4*c]   = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        o[4*c+1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
        o[4*c+2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
        o[4*c+3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
      end
    end
    for (int n = 0; n < 16; n++) enc_round[127-8*n -: 8] = o[n];
  endfunction

  // inverse shift/sub; key add and inverse mix follow
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [7:0] b [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        b[r + 4*((c + r) % 4)] = aes_pkg::sbox_dec(s[127 - 8*(r + 4*c) -: 8]);
    for (int n = 0; n < 16; n++) dec_sub[127-8*n -: 8] = b[n];
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[127 - 8*(4*c+j) -: 8];
      for (int r = 0; r < 4; r++)
        inv_mix[127 - 8*(4*c+r) -: 8] =
          aes_pkg::gmul(8'h0e, a[r]) ^ aes_pkg::gmul(8'h0b, a[(r+1)%4]) ^
          aes_pkg::gmul(8'h0d, a[(r+2)%4]) ^ aes_pkg::gmul(8'h09, a[(r+3)%4]);
    end
  endfunction

  always_comb begin
    st_d = st_q;
    if (cmd_i.load) begin
      st_d = {in_i.block_high, in_i.block_low};
    end else if (cmd_i.add0) begin
      st_d = st_q ^ rk_q;
    end else if (cmd_i.round) begin
      if (dec_q == aes_pkg::ActEncrypt) begin
        st_d = enc_round(st_q, cmd_i.last) ^ rk_q;
      end else begin
        st_d = dec_sub(st_q) ^ rk_q;
        if (!cmd_i.last) st_d = inv_mix(st_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) dec_q <= in_i.action;
    st_q <= st_d;
  end

  assign out_o = '{result_high: st_q[127:64], result_low: st_q[63:0]};

endmodule

>>> design/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer: load, key expansion sweep when the schedule is stale, then key add and round steps.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              key_dirty_i,   // register write this cycle
  input  logic [1:0]        mode_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_action_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aes_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StExpand, StFetch, StAdd0, StRound, StDone
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   dec_q, dec_d;
  logic [aes_pkg::KeyAddrW-1:0] idx_q, idx_d;
  logic [aes_pkg::RoundW-1:0]   rnd_q, rnd_d;
  logic [aes_pkg::RoundW-1:0]   nr;
  logic [3:0]                   nk;
  logic [aes_pkg::KeyAddrW-1:0] total_m1;
  logic   valid_q, valid_d;
  logic   accept;

  assign nk = (mode_i == aes_pkg::KeyMode128) ? 4'd4 :
              (mode_i == aes_pkg::KeyMode192) ? 4'd6 : 4'd8;
  assign nr = 4'(nk + 4'd6);
  assign total_m1 = 6'({nr, 2'b00} + 6'd3);

  assign in_stall_o  = !(state_q == StIdle && !(valid_q && out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = valid_q;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q && !key_dirty_i;
    dec_d = dec_q;
    idx_d = idx_q;
    rnd_d = rnd_q;
    valid_d = valid_q && out_stall_i;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          dec_d = in_action_i;
          cmd_o.load = 1'b1;
          if (ready_q) begin
            state_d = StAdd0;
            rnd_d = (in_action_i == aes_pkg::ActDecrypt) ? nr : '0;
            cmd_o.rk_fetch = 1'b1;
            cmd_o.rk_round = rnd_d;
          end else begin
            state_d = StExpand;
            idx_d = '0;
          end
        end
      end
      StExpand: begin
        cmd_o.key_wr = 1'b1;
        cmd_o.key_idx = idx_q;
        cmd_o.key_seed = (idx_q < 6'(nk));
        idx_d = 6'(idx_q + 6'd1);
        if (idx_q == total_m1) begin
          ready_d = 1'b1;
          rnd_d = (dec_q == aes_pkg::ActDecrypt) ? nr : '0;
          state_d = StFetch;
        end
      end
      StFetch: begin
        // store is complete now; read the first round key
        cmd_o.rk_fetch = 1'b1;
        cmd_o.rk_round = rnd_q;
        state_d = StAdd0;
      end
      StAdd0: begin
        cmd_o.add0 = 1'b1;
        state_d = StRound;
        rnd_d = (dec_q == aes_pkg::ActDecrypt) ? 4'(rnd_q - 4'd1) : 4'(rnd_q + 4'd1);
        cmd_o.rk_fetch = 1'b1;
        cmd_o.rk_round = rnd_d;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        cmd_o.last = (dec_q == aes_pkg::ActDecrypt) ? (rnd_q == '0) : (rnd_q == nr);
        if (cmd_o.last) begin
          state_d = StDone;
        end else begin
          rnd_d = (dec_q == aes_pkg::ActDecrypt) ? 4'(rnd_q - 4'd1) : 4'(rnd_q + 4'd1);
          cmd_o.rk_fetch = 1'b1;
          cmd_o.rk_round = rnd_d;
          state_d = StRound;
        end
      end
      StDone: begin
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b0;
      dec_q   <= 1'b0;
      idx_q   <= '0;
      rnd_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      dec_q   <= dec_d;
      idx_q   <= idx_d;
      rnd_q   <= rnd_d;
      valid_q <= valid_d;
    end
  end

endmodule

>>> design/aes_block_cipher_chk.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_chk
// Port-level checks for the AES block cipher.
// ----------------------------------------------------------------------------
module aes_block_cipher_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic pready
);

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken during work");

endmodule

bind aes_block_cipher aes_block_cipher_chk u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .pready
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES block cipher: directed and random bursty
// words in, a stalling sink out, each result compared with an in-bench AES
// predictor. Keys and size modes are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  aes_pkg::in_word_t          in_data_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  aes_pkg::out_word_t         out_data_o;
  logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [aes_pkg::PaddrW-1:0] paddr = '0;
  logic [63:0]                pwdata = '0;
  logic [63:0]                prdata;
  logic                       pready;

  aes_block_cipher dut (.*);

  // ---- predictor: own copy of the key registers and schedule ----
  logic [63:0] key_reg [4];
  logic [1:0]  size_mode;
  logic [31:0] rk [60];
  bit          rk_valid;

  function automatic logic [7:0] dbl8(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = dbl8(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] inv8(logic [7:0] x);
    logic [7:0] r;
    logic [7:0] e;
    r = 8'h01;
    e = 8'd254;
    while (e != 0) begin
      if (e[0]) r = mul8(r, x);
      x = mul8(x, x);
      e >>= 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rl8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] v;
    v = inv8(x);
    return v ^ rl8(v, 1) ^ rl8(v, 2) ^ rl8(v, 3) ^ rl8(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(logic [7:0] x);
    return inv8(rl8(x, 1) ^ rl8(x, 3) ^ rl8(x, 6) ^ 8'h05);
  endfunction

  function automatic int key_words();
    return (size_mode == aes_pkg::KeyMode128) ? 4 :
           (size_mode == aes_pkg::KeyMode192) ? 6 : 8;
  endfunction

  function automatic void build_schedule();
    int nk;
    logic [7:0] rc;
    logic [31:0] t;
    nk = key_words();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub(t[31:24]) ^ rc, fwd_sub(t[23:16]), fwd_sub(t[15:8]), fwd_sub(t[7:0])};
        rc = dbl8(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]), fwd_sub(t[7:0])};
      end
      rk[i] = rk[i-nk] ^ t;
    end
    rk_valid = 1;
  endfunction

  typedef logic [7:0] blk_t [16];

  function automatic void add_round(ref blk_t s, input int r);
    for (int c = 0; c < 4; c++)
      for (int b = 0; b < 4; b++) s[4*c+b] ^= rk[4*r+c][31-8*b -: 8];
  endfunction

  function automatic void shift(ref blk_t s, input bit inverse);
    blk_t t;
    t = s;
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (inverse) s[r + 4*((c+r)%4)] = t[r + 4*c];
        else s[r + 4*c] = t[r + 4*((c+r)%4)];
  endfunction

  function automatic void mix(ref blk_t s, input bit inverse);
    logic [7:0] k [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inverse) k = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else k = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) col[j] = s[4*c+j];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) acc ^= mul8(k[(j+4-r)%4], col[j]);
        s[4*c+r] = acc;
      end
    end
  endfunction

  function automatic aes_pkg::out_word_t aes_cipher(aes_pkg::in_word_t w);
    blk_t s;
    int nr;
    aes_pkg::out_word_t o;
    if (!rk_valid) build_schedule();
    nr = key_words() + 6;
    for (int i = 0; i < 8; i++) begin
      s[i] = w.block_high[63-8*i -: 8];
      s[8+i] = w.block_low[63-8*i -: 8];
    end
    if (w.action == aes_pkg::ActEncrypt) begin
      add_round(s, 0);
      for (int r = 1; r <= nr; r++) begin
        for (int i = 0; i < 16; i++) s[i] = fwd_sub(s[i]);
        shift(s, 0);
        if (r != nr) mix(s, 0);
        add_round(s, r);
      end
    end else begin
      add_round(s, nr);
      for (int r = nr - 1; r >= 0; r--) begin
        shift(s, 1);
        for (int i = 0; i < 16; i++) s[i] = rev_sub(s[i]);
        add_round(s, r);
        if (r != 0) mix(s, 1);
      end
    end
    for (int i = 0; i < 8; i++) begin
      o.result_high[63-8*i -: 8] = s[i];
      o.result_low[63-8*i -: 8] = s[8+i];
    end
    return o;
  endfunction

  // ---- queues and status ----
  aes_pkg::in_word_t  pending_words[$];
  aes_pkg::out_word_t expected_blocks[$];
  bit        fail = 0;
  bit        hold_tx = 1;     // driver waits while config is written
  int        idle_cycles = 0;

  // ---- driver: bursts and random gaps ----
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_blocks.push_back(aes_cipher(in_data_i));
      void'(pending_words.pop_front());
    end
    // valid stays up while the held word is not yet taken
    if (in_valid_i && in_stall_o) begin
    end else if (!hold_tx && pending_words.size() > 0 && gap_left == 0 &&
                 !(in_valid_i && pending_words.size() < 2)) begin
      // next word: front of queue after the pop above
      in_valid_i <= 1'b1;
      in_data_i  <= pending_words[0];
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      if (gap_left > 0) gap_left--;
    end
  end

  // ---- monitor and sink stall pattern ----
  aes_pkg::out_word_t want;
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        $error("result with nothing expected: %h", out_data_o);
        fail = 1;
      end else begin
        want = expected_blocks.pop_front();
        if (want.result_high !== out_data_o.result_high) begin
          $error("result_high exp %h got %h", want.result_high, out_data_o.result_high);
          fail = 1;
        end
        if (want.result_low !== out_data_o.result_low) begin
          $error("result_low exp %h got %h", want.result_low, out_data_o.result_low);
          fail = 1;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // ---- watchdog: cycles with no word accepted on either side and no APB access ----
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("aes_block_cipher: mismatch");
      $finish;
    end
  end

  // ---- APB write: setup then access ----
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= aes_pkg::PaddrW'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < aes_pkg::RegMode) key_reg[idx] = val;
    else if (idx == aes_pkg::RegMode) size_mode = val[1:0];
    if (idx <= aes_pkg::RegMode) rk_valid = 0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_blocks.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);   // covers a schedule expansion plus rounds
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic aes_pkg::in_word_t rnd_word();
    aes_pkg::in_word_t w;
    w.action = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin w.block_high = '1; w.block_low = '1; end
      1: begin w.block_high = '0; w.block_low = '0; end
      default: begin w.block_high = rnd64(); w.block_low = rnd64(); end
    endcase
    return w;
  endfunction

  task automatic program_key(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                             logic [63:0] k2, logic [63:0] k3);
    drain();
    hold_tx = 1;
    reg_write(aes_pkg::RegKey0, k0);
    reg_write(aes_pkg::RegKey1, k1);
    reg_write(aes_pkg::RegKey2, k2);
    reg_write(aes_pkg::RegKey3, k3);
    reg_write(aes_pkg::RegMode, {62'd0, mode});
    hold_tx = 0;
  endtask

  initial begin
    aes_pkg::in_word_t w;
    key_reg = '{default: '0};
    size_mode = aes_pkg::KeyMode128;
    rk_valid = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: FIPS-197 appendix C encrypt vectors for each size, plus other fixed blocks both ways
    program_key(aes_pkg::KeyMode128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                '0, '0);
    w = '{aes_pkg::ActEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff};
    pending_words.push_back(w);
    w.action = aes_pkg::ActDecrypt; pending_words.push_back(w);
    pending_words.push_back('{aes_pkg::ActEncrypt, '0, '0});
    pending_words.push_back('{aes_pkg::ActDecrypt, '1, '1});
    program_key(aes_pkg::KeyMode192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, '1);
    pending_words.push_back('{aes_pkg::ActEncrypt, 64'h0011223344556677,
                              64'h8899aabbccddeeff});
    pending_words.push_back('{aes_pkg::ActDecrypt, '1, '0});
    program_key(aes_pkg::KeyMode256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    pending_words.push_back('{aes_pkg::ActEncrypt, 64'h0011223344556677,
                              64'h8899aabbccddeeff});
    pending_words.push_back('{aes_pkg::ActDecrypt, '0, '1});
    // reserved size mode behaves as 256-bit
    program_key(aes_pkg::KeyModeRsvd, '1, '1, '1, '1);
    pending_words.push_back('{aes_pkg::ActEncrypt, '1, '1});
    pending_words.push_back('{aes_pkg::ActDecrypt, '0, '0});
    program_key(aes_pkg::KeyMode128, '0, '0, '1, '1);
    pending_words.push_back('{aes_pkg::ActEncrypt, '0, '0});

    // random phases, each with a fresh key and size
    for (int ph = 0; ph < 10; ph++) begin
      program_key(2'($urandom_range(0, 3)), rnd64(), rnd64(), rnd64(), rnd64());
      for (int i = 0; i < 100; i++) begin
        pending_words.push_back(rnd_word());
        // occasionally let everything complete before more arrive
        if (i == 50 && ph % 3 == 0) begin
          while (pending_words.size() > 0 || expected_blocks.size() > 0)
            @(posedge clk_i);
        end
      end
    end

    drain();
    hold_tx = 1;
    if (!fail) begin
      $display("aes_block_cipher: match");
    end else begin
      $display("aes_block_cipher: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
design/aes_pkg.sv
design/aes_datapath.sv
design/aes_ctrl.sv
design/aes_block_cipher.sv
design/aes_block_cipher_chk.sv
test/tb_top.sv
